FILE: design/remote_control_frame_serializer_unit_assert.svh
// Assertion macros shared by the checker files of the frame serializer.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef REMOTE_CONTROL_FRAME_SERIALIZER_UNIT_ASSERT_SVH
`define REMOTE_CONTROL_FRAME_SERIALIZER_UNIT_ASSERT_SVH

// Checked only while the block is out of reset.
`define RCFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define RCFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/rcfs_pkg.sv
// Shared types and constants of the remote-control frame serializer.
// No dependencies.
package rcfs_pkg;

  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;
  localparam int unsigned LenW       = 6;
  localparam int unsigned CodeW      = 16;
  localparam int unsigned FrameW     = 48;
  localparam int unsigned IdxW       = 6;
  localparam int unsigned QueueDepth = 2;

  localparam logic [LenW-1:0]  HdrHighReset = 6'd16;
  localparam logic [LenW-1:0]  HdrLowReset  = 6'd9;
  localparam logic [23:0]      FramePrefix  = 24'hD7DBAB;
  localparam logic [7:0]       EndByteOdd   = 8'h55;
  localparam logic [7:0]       EndByteEven  = 8'hD5;
  localparam logic [IdxW-1:0]  FrameBits    = 6'd48;

  localparam logic [0:0] RegHdrHigh = 1'b0;
  localparam logic [0:0] RegHdrLow  = 1'b1;

  typedef enum logic {
    CmdTick = 1'b0,
    CmdSend = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e             kind;
    logic [CodeW-1:0] code;
  } item_t;

  typedef struct packed {
    logic [LenW-1:0] hdr_high;
    logic [LenW-1:0] hdr_low;
  } cfg_t;

endpackage

FILE: design/rcfs_regs.sv
// Configuration registers of the frame serializer behind an APB-style port.
// Depends on rcfs_pkg.
module rcfs_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcfs_pkg::AddrW-1:0] paddr,
  input  logic [rcfs_pkg::DataW-1:0] pwdata,
  output logic [rcfs_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output rcfs_pkg::cfg_t             cfg_o
);
  import rcfs_pkg::*;

  logic [LenW-1:0] hdr_high_q, hdr_high_d;
  logic [LenW-1:0] hdr_low_q, hdr_low_d;
  logic [0:0]      reg_idx;
  logic            wr_en;

  assign reg_idx = paddr[2:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    hdr_high_d = hdr_high_q;
    hdr_low_d  = hdr_low_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegHdrHigh: hdr_high_d = pwdata[LenW-1:0];
        RegHdrLow:  hdr_low_d  = pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegHdrHigh: prdata = {{(DataW-LenW){1'b0}}, hdr_high_q};
      RegHdrLow:  prdata = {{(DataW-LenW){1'b0}}, hdr_low_q};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_high_q <= HdrHighReset;
      hdr_low_q  <= HdrLowReset;
    end else begin
      hdr_high_q <= hdr_high_d;
      hdr_low_q  <= hdr_low_d;
    end
  end

  assign cfg_o.hdr_high = hdr_high_q;
  assign cfg_o.hdr_low  = hdr_low_q;

endmodule

FILE: design/rcfs_front.sv
// Front end: accepts requests, classifies them and queues them for the engine.
// Depends on rcfs_pkg.
module rcfs_front #(
  parameter int unsigned Depth = rcfs_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic [rcfs_pkg::CodeW-1:0] frame_code_i,
  output logic                       q_valid_o,
  output rcfs_pkg::item_t            q_item_o,
  input  logic                       q_pop_i
);
  import rcfs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           entry_q [Depth];
  item_t           in_item;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;

  assign in_item.kind = cmd_e'(command_i);
  assign in_item.code = frame_code_i;

  assign in_ready_o = (cnt_q != FullCnt);
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = entry_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

FILE: design/rcfs_engine.sv
// Back end: frame sequencer that runs header, gap and bit slots, plus the result register.
// Depends on rcfs_pkg.
module rcfs_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rcfs_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  rcfs_pkg::item_t q_item_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            line_level_o,
  output logic            busy_res_o,
  output logic            frame_done_o,
  output logic            send_rejected_o
);
  import rcfs_pkg::*;

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhHeader = 2'd1;
  localparam logic [1:0] PhGap    = 2'd2;
  localparam logic [1:0] PhBits   = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic [LenW-1:0]   tick_q, tick_d, tick_inc;
  logic [IdxW-1:0]   bit_q, bit_d;
  logic              half_q, half_d;
  logic [FrameW-1:0] shift_q, shift_d;
  logic              out_valid_q;
  logic              line_q, busy_q, done_q, rej_q;
  logic              line_d, done_d, rej_d;
  logic              pop;

  function automatic logic len_reached(logic [LenW-1:0] cnt, logic [LenW-1:0] len);
    logic [LenW-1:0] eff;
    eff = (len == '0) ? LenW'(1) : len;
    return cnt >= eff;
  endfunction

  assign pop      = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o  = pop;
  assign tick_inc = tick_q + 1'b1;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    half_d  = half_q;
    shift_d = shift_q;
    done_d  = 1'b0;
    rej_d   = 1'b0;
    if (pop) begin
      if (q_item_i.kind == CmdSend) begin
        if (phase_q != PhIdle) begin
          rej_d = 1'b1;
        end else begin
          shift_d = {FramePrefix, q_item_i.code,
                     q_item_i.code[0] ? EndByteOdd : EndByteEven};
          phase_d = PhHeader;
          tick_d  = '0;
          bit_d   = '0;
          half_d  = 1'b0;
        end
      end else begin
        unique case (phase_q)
          PhIdle: ;
          PhHeader: begin
            tick_d = tick_inc;
            if (len_reached(tick_inc, cfg_i.hdr_high)) begin
              phase_d = PhGap;
              tick_d  = '0;
            end
          end
          PhGap: begin
            tick_d = tick_inc;
            if (len_reached(tick_inc, cfg_i.hdr_low)) begin
              phase_d = PhBits;
              tick_d  = '0;
              bit_d   = '0;
              half_d  = 1'b0;
            end
          end
          PhBits: begin
            if (!half_q) begin
              half_d = 1'b1;
            end else begin
              half_d  = 1'b0;
              bit_d   = bit_q + 1'b1;
              shift_d = {shift_q[FrameW-2:0], 1'b0};
              if (bit_d >= FrameBits) begin
                done_d  = 1'b1;
                phase_d = PhIdle;
                bit_d   = '0;
                tick_d  = '0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    line_d = 1'b0;
    if (phase_d == PhHeader) begin
      line_d = 1'b1;
    end else if (phase_d == PhBits && !half_d) begin
      line_d = shift_d[FrameW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      tick_q      <= '0;
      bit_q       <= '0;
      half_q      <= 1'b0;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      half_q  <= half_d;
      shift_q <= shift_d;
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      line_q <= line_d;
      busy_q <= (phase_d != PhIdle);
      done_q <= done_d;
      rej_q  <= rej_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_level_o    = line_q;
  assign busy_res_o      = busy_q;
  assign frame_done_o    = done_q;
  assign send_rejected_o = rej_q;

endmodule

FILE: design/remote_control_frame_serializer_unit.sv
// Top level of the remote-control frame serializer: registers, request queue and engine.
// Depends on rcfs_pkg, rcfs_regs, rcfs_front and rcfs_engine.
//
//   Channel   Direction  Handshake                 Payload
//   in        request    in_valid_i / in_ready_o   command_i, frame_code_i
//   out       result     out_valid_o / out_ready_i line_level_o, busy_res_o, frame_done_o,
//                                                  send_rejected_o
//   config    APB access psel, penable, pwrite     paddr, pwdata, prdata
//
// One request per clock is sustained while the output is taken. A result is registered
// at the edge its request leaves the queue, where it was written at acceptance. The limit
// is the sequencer step that updates the frame state per request.
// Reset clears the queue, the sequencer and out_valid_o; lengths return to 16 and 9.
// A stalled output holds its result while the queue keeps taking requests until it is full.
module remote_control_frame_serializer_unit #(
  parameter int unsigned QueueDepth = rcfs_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcfs_pkg::AddrW-1:0] paddr,
  input  logic [rcfs_pkg::DataW-1:0] pwdata,
  output logic [rcfs_pkg::DataW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic [rcfs_pkg::CodeW-1:0] frame_code_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       line_level_o,
  output logic                       busy_res_o,
  output logic                       frame_done_o,
  output logic                       send_rejected_o
);
  import rcfs_pkg::*;

  cfg_t  cfg;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  rcfs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rcfs_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .frame_code_i (frame_code_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  rcfs_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .line_level_o    (line_level_o),
    .busy_res_o      (busy_res_o),
    .frame_done_o    (frame_done_o),
    .send_rejected_o (send_rejected_o)
  );

endmodule

FILE: design/rcfs_checker.sv
// Port-level checker of the frame serializer and its bind to the top level.
// Depends on the assertion macro header.
`include "remote_control_frame_serializer_unit_assert.svh"

module rcfs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic line_level_o,
  input logic busy_res_o,
  input logic frame_done_o,
  input logic send_rejected_o
);

  logic [3:0] res;
  logic       stall;
  logic       done_seen;
  logic       rej_seen;
  logic       high_seen;

  assign res       = {line_level_o, busy_res_o, frame_done_o, send_rejected_o};
  assign stall     = out_valid_o && !out_ready_i;
  assign done_seen = out_valid_o && frame_done_o;
  assign rej_seen  = out_valid_o && send_rejected_o;
  assign high_seen = out_valid_o && line_level_o;

  `RCFS_ASSERT(a_out_hold, stall |=> out_valid_o && $stable(res), "Stalled result changed.")
  `RCFS_ASSERT_ALWAYS(a_done_idle, done_seen |-> !busy_res_o && !line_level_o, "Done while busy.")
  `RCFS_ASSERT_ALWAYS(a_rej_busy, rej_seen |-> busy_res_o && !frame_done_o, "Reject while idle.")
  `RCFS_ASSERT_ALWAYS(a_line_busy, high_seen |-> busy_res_o, "Line high while idle.")

endmodule

bind remote_control_frame_serializer_unit rcfs_checker u_rcfs_checker (.*);
